// ----- rtl/bml_pkg.sv -----
`default_nettype none

package bml_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LIGHT_X          = 3'd0;
    localparam logic [2:0] CFG_LIGHT_Y          = 3'd1;
    localparam logic [2:0] CFG_DEPTH_PERCENT    = 3'd2;
    localparam logic [2:0] CFG_INVERT_DEPTH     = 3'd3;
    localparam logic [2:0] CFG_BLEND_SELECT     = 3'd4;
    localparam logic [2:0] CFG_DEPTH_FROM_FRAME = 3'd5;
    localparam logic [2:0] CFG_SHOW_LIGHT       = 3'd6;

    // Blend modes. The unused code falls back to replace.
    localparam logic [1:0] BLEND_REPLACE = 2'd0;
    localparam logic [1:0] BLEND_ADD     = 2'd1;
    localparam logic [1:0] BLEND_MEAN    = 2'd2;

    // Fixed arithmetic constants.
    localparam logic [6:0]  SHAPE_LIMIT     = 7'd127;
    localparam logic [9:0]  BYTE_CLAMP      = 10'd254;
    localparam logic [6:0]  DEPTH_PCT_RESET = 7'd30;
    localparam logic [31:0] WHITE_PIXEL     = 32'h00FF_FFFF;
    localparam logic [31:0] AVG_KEEP_MASK   = ~32'h0080_8080;

    // Reciprocal of 100 scaled by 2^19; multiplying by 256 folds into a shift of 11.
    localparam logic [12:0] PCT_RECIP = 13'd5243;

    // Depth of a pixel: largest of the three color bytes, optionally inverted.
    function automatic logic [7:0] depth_of(input logic [31:0] p, input logic inv);
        logic [7:0] m;
        m = (p[7:0] > p[15:8]) ? p[7:0] : p[15:8];
        if (p[23:16] > m) begin
            m = p[23:16];
        end
        return inv ? (8'hFF - m) : m;
    endfunction

    // Scaled depth (dp * 256) / 100, exact for every 7-bit percentage.
    function automatic logic [8:0] depth_scale(input logic [6:0] dp);
        logic [19:0] prod;
        prod = 20'(dp) * 20'(PCT_RECIP);
        return prod[19:11];
    endfunction

    // Color byte plus brightness, clamped to 254.
    function automatic logic [7:0] lit_byte(input logic [7:0] b, input logic [8:0] l);
        logic [9:0] v;
        v = 10'(b) + 10'(l);
        return (v > BYTE_CLAMP) ? BYTE_CLAMP[7:0] : v[7:0];
    endfunction

    // Saturating byte add for the additive blend.
    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] v;
        v = {1'b0, a} + {1'b0, b};
        return v[8] ? 8'hFF : v[7:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bump_map_pixel_lighting.sv -----
// Bump-map lighting, one output pixel per input item.
// Input channel: i_in_valid with the payload ports; the block drives o_in_stall.
// An item is taken at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid with o_out_pixel; the receiver drives i_out_stall.
// Configuration: i_cfg_valid, i_cfg_index and i_cfg_data, with o_cfg_ready always
// high; write only while no item is in flight.
// Pipeline: five register stages (depth and distances, gradient shaping,
// shape product, brightness scaling, clamp and blend). Throughput: one item
// per cycle. Each stage holds only while the stage after it is full and held,
// so bubbles close up and a stalled receiver backs the pipeline up one stage
// at a time; o_in_stall rises only when all five stages are full and the
// output is stalled.
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults: light at MAX_DIM/2 in both axes, depth 30 percent, no inversion,
// replace mode, depth taken from the frame, light dot hidden.
`default_nettype none

module bump_map_pixel_lighting #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration write port.
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [2:0]                   i_cfg_index,
    input  wire logic [$clog2(MAX_DIM):0]     i_cfg_data,
    // Input channel.
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [31:0]                  i_source_pixel,
    input  wire logic [31:0]                  i_depth_left,
    input  wire logic [31:0]                  i_depth_right,
    input  wire logic [31:0]                  i_depth_up,
    input  wire logic [31:0]                  i_depth_down,
    input  wire logic [$clog2(MAX_DIM)-1:0]   i_column,
    input  wire logic [$clog2(MAX_DIM)-1:0]   i_row,
    input  wire logic                         i_on_border,
    // Output channel.
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [31:0]                       o_out_pixel
);

    localparam int CW  = $clog2(MAX_DIM);
    localparam int LW  = CW + 1;
    localparam int DW  = CW + 2;
    localparam int GW  = ((DW > 10) ? DW : 10) + 1;

    // Configuration registers.
    logic [LW-1:0] r_light_x;
    logic [LW-1:0] r_light_y;
    logic [8:0]    r_depth_scale;
    logic          r_invert_depth;
    logic [1:0]    r_blend_select;
    logic          r_depth_from_frame;
    logic          r_show_light;

    assign o_cfg_ready = 1'b1;

    // Register writes; the depth percentage is kept already scaled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x          <= LW'(MAX_DIM / 2);
            r_light_y          <= LW'(MAX_DIM / 2);
            r_depth_scale      <= bml_pkg::depth_scale(bml_pkg::DEPTH_PCT_RESET);
            r_invert_depth     <= 1'b0;
            r_blend_select     <= bml_pkg::BLEND_REPLACE;
            r_depth_from_frame <= 1'b1;
            r_show_light       <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bml_pkg::CFG_LIGHT_X:          r_light_x <= i_cfg_data[LW-1:0];
                bml_pkg::CFG_LIGHT_Y:          r_light_y <= i_cfg_data[LW-1:0];
                bml_pkg::CFG_DEPTH_PERCENT: begin
                    r_depth_scale <= bml_pkg::depth_scale(i_cfg_data[6:0]);
                end
                bml_pkg::CFG_INVERT_DEPTH:     r_invert_depth <= i_cfg_data[0];
                bml_pkg::CFG_BLEND_SELECT:     r_blend_select <= i_cfg_data[1:0];
                bml_pkg::CFG_DEPTH_FROM_FRAME: r_depth_from_frame <= i_cfg_data[0];
                bml_pkg::CFG_SHOW_LIGHT:       r_show_light <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Stage valid bits and per-stage load enables.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic s1_en, s2_en, s3_en, s4_en, s5_en;

    assign s5_en = !r_v5 || !i_out_stall;
    assign s4_en = !r_v4 || s5_en;
    assign s3_en = !r_v3 || s4_en;
    assign s2_en = !r_v2 || s3_en;
    assign s1_en = !r_v1 || s2_en;

    assign o_in_stall  = !s1_en;
    assign o_out_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (s1_en) r_v1 <= i_in_valid;
            if (s2_en) r_v2 <= r_v1;
            if (s3_en) r_v3 <= r_v2;
            if (s4_en) r_v4 <= r_v3;
            if (s5_en) r_v5 <= r_v4;
        end
    end

    // Stage 1: neighbor depths, light distances and the skip decision.
    logic [7:0]        s1_dl, s1_dr, s1_du, s1_dd;
    logic signed [DW-1:0] s1_lx, s1_ly;
    logic              s1_skip, s1_white;

    always_comb begin
        s1_dl    = bml_pkg::depth_of(i_depth_left,  r_invert_depth);
        s1_dr    = bml_pkg::depth_of(i_depth_right, r_invert_depth);
        s1_du    = bml_pkg::depth_of(i_depth_up,    r_invert_depth);
        s1_dd    = bml_pkg::depth_of(i_depth_down,  r_invert_depth);
        s1_lx    = $signed({2'b00, i_column}) - $signed({1'b0, r_light_x});
        s1_ly    = $signed({2'b00, i_row}) - $signed({1'b0, r_light_y});
        s1_skip  = i_on_border || (r_depth_from_frame &&
                   !(|{i_depth_left, i_depth_right, i_depth_up, i_depth_down}));
        s1_white = r_show_light && ({1'b0, i_column} == r_light_x)
                   && ({1'b0, i_row} == r_light_y);
    end

    logic [31:0]          r_s1_src;
    logic [7:0]           r_s1_dl, r_s1_dr, r_s1_du, r_s1_dd;
    logic signed [DW-1:0] r_s1_lx, r_s1_ly;
    logic                 r_s1_skip, r_s1_white;

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_s1_src   <= i_source_pixel;
            r_s1_dl    <= s1_dl;
            r_s1_dr    <= s1_dr;
            r_s1_du    <= s1_du;
            r_s1_dd    <= s1_dd;
            r_s1_lx    <= s1_lx;
            r_s1_ly    <= s1_ly;
            r_s1_skip  <= s1_skip;
            r_s1_white <= s1_white;
        end
    end

    // Stage 2: gradients less distance, shaped as 127 - |g|.
    logic signed [GW-1:0] s2_gx, s2_gy;
    logic [GW-1:0]        s2_ax, s2_ay;
    logic                 s2_pos;
    logic [6:0]           s2_t1, s2_t2;

    always_comb begin
        s2_gx  = $signed({{(GW-8){1'b0}}, r_s1_dr}) - $signed({{(GW-8){1'b0}}, r_s1_dl})
                 - $signed({{(GW-DW){r_s1_lx[DW-1]}}, r_s1_lx});
        s2_gy  = $signed({{(GW-8){1'b0}}, r_s1_dd}) - $signed({{(GW-8){1'b0}}, r_s1_du})
                 - $signed({{(GW-DW){r_s1_ly[DW-1]}}, r_s1_ly});
        s2_ax  = s2_gx[GW-1] ? GW'(-s2_gx) : GW'(s2_gx);
        s2_ay  = s2_gy[GW-1] ? GW'(-s2_gy) : GW'(s2_gy);
        s2_pos = (s2_ax < {{(GW-7){1'b0}}, bml_pkg::SHAPE_LIMIT})
                 && (s2_ay < {{(GW-7){1'b0}}, bml_pkg::SHAPE_LIMIT});
        s2_t1  = bml_pkg::SHAPE_LIMIT - s2_ax[6:0];
        s2_t2  = bml_pkg::SHAPE_LIMIT - s2_ay[6:0];
    end

    logic [31:0] r_s2_src;
    logic [6:0]  r_s2_t1, r_s2_t2;
    logic        r_s2_pos, r_s2_skip, r_s2_white;

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_s2_src   <= r_s1_src;
            r_s2_t1    <= s2_t1;
            r_s2_t2    <= s2_t2;
            r_s2_pos   <= s2_pos;
            r_s2_skip  <= r_s1_skip;
            r_s2_white <= r_s1_white;
        end
    end

    // Stage 3: product of the shaped terms; zero when either is not positive.
    logic [31:0] r_s3_src;
    logic [13:0] r_s3_prod;
    logic        r_s3_skip, r_s3_white;

    always_ff @(posedge i_clk) begin
        if (s3_en) begin
            r_s3_src   <= r_s2_src;
            r_s3_prod  <= r_s2_pos ? (14'(r_s2_t1) * 14'(r_s2_t2)) : 14'd0;
            r_s3_skip  <= r_s2_skip;
            r_s3_white <= r_s2_white;
        end
    end

    // Stage 4: brightness = (product * scaled depth) >> 14.
    logic [22:0] s4_full;

    assign s4_full = 23'(r_s3_prod) * 23'(r_depth_scale);

    logic [31:0] r_s4_src;
    logic [8:0]  r_s4_light;
    logic        r_s4_skip, r_s4_white;

    always_ff @(posedge i_clk) begin
        if (s4_en) begin
            r_s4_src   <= r_s3_src;
            r_s4_light <= s4_full[22:14];
            r_s4_skip  <= r_s3_skip;
            r_s4_white <= r_s3_white;
        end
    end

    // Stage 5: lit pixel, blend, and the cleared-pixel override.
    logic [31:0] s5_lit, s5_blend, s5_result;

    always_comb begin
        s5_lit = {r_s4_src[31:24],
                  bml_pkg::lit_byte(r_s4_src[23:16], r_s4_light),
                  bml_pkg::lit_byte(r_s4_src[15:8],  r_s4_light),
                  bml_pkg::lit_byte(r_s4_src[7:0],   r_s4_light)};
        unique case (r_blend_select)
            bml_pkg::BLEND_ADD: begin
                s5_blend = {8'h00,
                            bml_pkg::sat_add(r_s4_src[23:16], s5_lit[23:16]),
                            bml_pkg::sat_add(r_s4_src[15:8],  s5_lit[15:8]),
                            bml_pkg::sat_add(r_s4_src[7:0],   s5_lit[7:0])};
            end
            bml_pkg::BLEND_MEAN: begin
                s5_blend = ((r_s4_src >> 1) & bml_pkg::AVG_KEEP_MASK)
                           + ((s5_lit >> 1) & bml_pkg::AVG_KEEP_MASK);
            end
            default: begin
                s5_blend = s5_lit;
            end
        endcase
        if (r_s4_skip) begin
            s5_result = r_s4_white ? bml_pkg::WHITE_PIXEL : 32'd0;
        end else begin
            s5_result = s5_blend;
        end
    end

    logic [31:0] r_out_pixel;

    always_ff @(posedge i_clk) begin
        if (s5_en) begin
            r_out_pixel <= s5_result;
        end
    end

    assign o_out_pixel = r_out_pixel;

    // The input is held back only when every stage is occupied.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5))
        else $error("input stalled while a pipeline stage is empty");

    // An item leaving the last inner stage shows up at the output.
    a_item_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && s5_en) |=> o_out_valid)
        else $error("item lost between brightness stage and output");

    // A taken result with nothing behind it leaves the output empty.
    a_output_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !r_v4) |=> !o_out_valid)
        else $error("result repeated at the output");

    // A cleared pixel is either zero or the white light dot.
    a_skip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && s5_en && r_s4_skip) |=>
        (o_out_pixel == 32'd0 || o_out_pixel == bml_pkg::WHITE_PIXEL))
        else $error("cleared pixel has an unexpected value");

endmodule

`default_nettype wire

// ----- test/bump_map_pixel_lighting_tb.sv -----
`timescale 1ns / 1ps

module bump_map_pixel_lighting_tb;

    // The spare blend code has no name in the package; it behaves as replace.
    localparam logic [1:0] BLEND_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int PHASES = 8;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] up;
        logic [31:0] down;
        logic [11:0] col;
        logic [11:0] row;
        logic        border;
    } t_pixel_item;

    typedef struct packed {
        logic [12:0] light_x;
        logic [12:0] light_y;
        logic [6:0]  depth_pct;
        logic        invert;
        logic [1:0]  blend;
        logic        from_frame;
        logic        show_dot;
    } t_lighting_cfg;

    typedef struct {
        t_pixel_item item;
        bit          fixed;
        logic [31:0] value;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [12:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_source_pixel;
    logic [31:0] i_depth_left;
    logic [31:0] i_depth_right;
    logic [31:0] i_depth_up;
    logic [31:0] i_depth_down;
    logic [11:0] i_column;
    logic [11:0] i_row;
    logic        i_on_border;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_out_pixel;

    t_lighting_cfg cur_cfg;
    logic [31:0]   pending_pixels[$];
    t_directed_row directed_rows[$];
    int            mismatches = 0;
    int            cycle_count = 0;
    int            stall_left = 0;
    bit            steady = 1'b0;
    logic [31:0]   want_pixel;

    bump_map_pixel_lighting #(
        .MAX_DIM(4096)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_source_pixel (i_source_pixel),
        .i_depth_left   (i_depth_left),
        .i_depth_right  (i_depth_right),
        .i_depth_up     (i_depth_up),
        .i_depth_down   (i_depth_down),
        .i_column       (i_column),
        .i_row          (i_row),
        .i_on_border    (i_on_border),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_pixel    (o_out_pixel)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Depth of one neighbor: its largest color byte, optionally inverted.
    function automatic int depth_level(logic [31:0] p, logic invert);
        logic [7:0] m;
        m = p[7:0];
        if (p[15:8] > m) begin
            m = p[15:8];
        end
        if (p[23:16] > m) begin
            m = p[23:16];
        end
        return invert ? 255 - int'(m) : int'(m);
    endfunction

    // Expected output pixel for one item under the given register settings.
    function automatic logic [31:0] shade_pixel(t_pixel_item it, t_lighting_cfg c);
        int          dx;
        int          dy;
        int          g1;
        int          g2;
        int          t1;
        int          t2;
        int          bright;
        int          scaled;
        int          v;
        logic [31:0] lit;
        logic [31:0] res;
        if (it.border || (c.from_frame && (it.left | it.right | it.up | it.down) == 32'd0)) begin
            return (c.show_dot && {1'b0, it.col} == c.light_x && {1'b0, it.row} == c.light_y)
                ? bml_pkg::WHITE_PIXEL : 32'd0;
        end
        dx = int'(it.col) - int'(c.light_x);
        dy = int'(it.row) - int'(c.light_y);
        g1 = depth_level(it.right, c.invert) - depth_level(it.left, c.invert) - dx;
        g2 = depth_level(it.down, c.invert) - depth_level(it.up, c.invert) - dy;
        if (g1 < 0) begin
            g1 = -g1;
        end
        if (g2 < 0) begin
            g2 = -g2;
        end
        t1 = int'(bml_pkg::SHAPE_LIMIT) - g1;
        t2 = int'(bml_pkg::SHAPE_LIMIT) - g2;
        bright = 0;
        if (t1 > 0 && t2 > 0) begin
            scaled = (int'(c.depth_pct) * 256) / 100;
            bright = (t1 * t2 * scaled) >>> 14;
        end
        // Brighten the color bytes with a clamp at 254; alpha passes through.
        lit = 32'd0;
        lit[31:24] = it.src[31:24];
        for (int k = 0; k < 3; k++) begin
            v = int'(it.src[8*k +: 8]) + bright;
            if (v > 254) begin
                v = 254;
            end
            lit[8*k +: 8] = v[7:0];
        end
        case (c.blend)
            bml_pkg::BLEND_ADD: begin
                res = 32'd0;
                for (int k = 0; k < 3; k++) begin
                    v = int'(it.src[8*k +: 8]) + int'(lit[8*k +: 8]);
                    if (v > 255) begin
                        v = 255;
                    end
                    res[8*k +: 8] = v[7:0];
                end
            end
            bml_pkg::BLEND_MEAN: begin
                res = ((it.src >> 1) & bml_pkg::AVG_KEEP_MASK)
                      + ((lit >> 1) & bml_pkg::AVG_KEEP_MASK);
            end
            default: begin
                res = lit;
            end
        endcase
        return res;
    endfunction

    function automatic t_pixel_item pix(logic [31:0] src, logic [31:0] left,
                                        logic [31:0] right, logic [31:0] up,
                                        logic [31:0] down, logic [11:0] col,
                                        logic [11:0] row, logic border);
        t_pixel_item it;
        it.src = src;
        it.left = left;
        it.right = right;
        it.up = up;
        it.down = down;
        it.col = col;
        it.row = row;
        it.border = border;
        return it;
    endfunction

    // Idle length: mostly from the shortest of three ranges, now and then from the longest.
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return $urandom_range(2, 1);
        end else if (r < 95) begin
            return $urandom_range(8, 3);
        end
        return $urandom_range(40, 20);
    endfunction

    // A coordinate close to the light, kept inside the image.
    function automatic logic [11:0] near_light(logic [12:0] l);
        int v;
        v = int'(l) + int'($urandom_range(400)) - 200;
        if (v < 0) begin
            v = 0;
        end
        if (v > 4095) begin
            v = 4095;
        end
        return v[11:0];
    endfunction

    // Random item. Positions cluster around the light so that the lit path is
    // taken often; neighbors are often smooth so that gradients stay small.
    function automatic t_pixel_item rand_pixel(t_lighting_cfg c);
        t_pixel_item it;
        logic [31:0] base;
        int          sel;
        int          place;
        it.src = $urandom;
        if ($urandom_range(3) == 0) begin
            it.src = it.src | 32'h00F0_F0F0;
        end
        sel = $urandom_range(15);
        if (sel <= 1) begin
            it.left = 32'd0;
            it.right = 32'd0;
            it.up = 32'd0;
            it.down = 32'd0;
        end else if (sel <= 8) begin
            base = $urandom;
            it.left = base ^ ($urandom & 32'h0F0F_0F0F);
            it.right = base ^ ($urandom & 32'h0F0F_0F0F);
            it.up = base ^ ($urandom & 32'h0F0F_0F0F);
            it.down = base ^ ($urandom & 32'h0F0F_0F0F);
        end else begin
            it.left = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
            it.right = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
            it.up = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
            it.down = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
        end
        it.border = ($urandom_range(15) == 0);
        place = $urandom_range(9);
        if (place == 0) begin
            it.col = (c.light_x > 13'd4095) ? 12'd4095 : c.light_x[11:0];
            it.row = (c.light_y > 13'd4095) ? 12'd4095 : c.light_y[11:0];
            it.border = ($urandom_range(2) == 0);
        end else if (place <= 6) begin
            it.col = near_light(c.light_x);
            it.row = near_light(c.light_y);
        end else begin
            it.col = 12'($urandom_range(4095));
            it.row = 12'($urandom_range(4095));
        end
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at cycle %0d: %s got %08h want %08h", cycle_count, what, got,
                 want);
        mismatches++;
    endtask

    // Offer one item, with an optional gap before it, and hold it until taken.
    task automatic send_item(t_pixel_item it, bit fixed, logic [31:0] fixed_value);
        int gap;
        bit stalled;
        gap = (steady || $urandom_range(2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_source_pixel <= it.src;
        i_depth_left <= it.left;
        i_depth_right <= it.right;
        i_depth_up <= it.up;
        i_depth_down <= it.down;
        i_column <= it.col;
        i_row <= it.row;
        i_on_border <= it.border;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        pending_pixels.push_back(fixed ? fixed_value : shade_pixel(it, cur_cfg));
    endtask

    // One register write; the caller lowers the valid after its last write.
    task automatic write_reg(logic [2:0] idx, logic [12:0] data);
        bit taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic program_lighting(t_lighting_cfg c);
        write_reg(bml_pkg::CFG_LIGHT_X, c.light_x);
        write_reg(bml_pkg::CFG_LIGHT_Y, c.light_y);
        write_reg(bml_pkg::CFG_DEPTH_PERCENT, 13'(c.depth_pct));
        write_reg(bml_pkg::CFG_INVERT_DEPTH, 13'(c.invert));
        write_reg(bml_pkg::CFG_BLEND_SELECT, 13'(c.blend));
        write_reg(bml_pkg::CFG_DEPTH_FROM_FRAME, 13'(c.from_frame));
        write_reg(bml_pkg::CFG_SHOW_LIGHT, 13'(c.show_dot));
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver: random stalls of mixed length; no new stall starts while the sender runs steady.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (!steady && $urandom_range(3) == 0) begin
                stall_left <= idle_len();
            end
        end
    end

    // Compare each accepted pixel with the oldest pending one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("pixel with nothing pending", o_out_pixel, 32'd0);
            end else begin
                want_pixel = pending_pixels.pop_front();
                if (o_out_pixel !== want_pixel) begin
                    report_mismatch("out_pixel", o_out_pixel, want_pixel);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_lighting_cfg c;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= bml_pkg::CFG_LIGHT_X;
        i_cfg_data <= 13'd0;
        i_in_valid <= 1'b0;
        i_source_pixel <= 32'd0;
        i_depth_left <= 32'd0;
        i_depth_right <= 32'd0;
        i_depth_up <= 32'd0;
        i_depth_down <= 32'd0;
        i_column <= 12'd0;
        i_row <= 12'd0;
        i_on_border <= 1'b0;
        cur_cfg = '{13'd2048, 13'd2048, bml_pkg::DEPTH_PCT_RESET, 1'b0,
                    bml_pkg::BLEND_REPLACE, 1'b1, 1'b0};

        // Directed items under the reset settings (light at 2048, 2048; 30 percent).
        // Border pixels, all-zero neighbors and the border at the light read zero.
        directed_rows.push_back('{pix(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd4095, 12'd4095, 1'b1), 1'b1, 32'd0});
        directed_rows.push_back('{pix(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0,
            12'd2048, 12'd2048, 1'b0), 1'b1, 32'd0});
        directed_rows.push_back('{pix(32'h1234_5678, 32'h0001_0101, 32'h0001_0101,
            32'h0001_0101, 32'h0001_0101, 12'd2048, 12'd2048, 1'b1), 1'b1, 32'd0});
        // Flat depth at the light: full shaping, brightness 74.
        directed_rows.push_back('{pix(32'h1234_5678, 32'h0001_0101, 32'h0001_0101,
            32'h0001_0101, 32'h0001_0101, 12'd2048, 12'd2048, 1'b0), 1'b0, 32'd0});
        directed_rows.push_back('{pix(32'h0000_0000, 32'h0001_0101, 32'h0001_0101,
            32'h0001_0101, 32'h0001_0101, 12'd2048, 12'd2048, 1'b0), 1'b1, 32'h004A_4A4A});
        // Saturated color clamps to 254 with or without light; alpha is kept.
        directed_rows.push_back('{pix(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF,
            32'h00FF_FFFF, 32'h00FF_FFFF, 12'd2048, 12'd2048, 1'b0), 1'b1, 32'hFFFE_FEFE});
        directed_rows.push_back('{pix(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF,
            32'h00FF_FFFF, 32'h00FF_FFFF, 12'd0, 12'd0, 1'b0), 1'b1, 32'hFFFE_FEFE});
        directed_rows.push_back('{pix(32'h0000_0000, 32'h0012_3456, 32'h0065_4321,
            32'h00AB_CDEF, 32'h0011_2233, 12'd100, 12'd3000, 1'b0), 1'b1, 32'd0});
        // Steepest gradients in both directions, cancelled by the distance.
        directed_rows.push_back('{pix(32'h4040_4040, 32'h0000_0000, 32'h00FF_0000,
            32'h0000_0010, 32'h0000_0010, 12'd2303, 12'd2048, 1'b0), 1'b0, 32'd0});
        directed_rows.push_back('{pix(32'h4040_4040, 32'h0000_00FF, 32'h0000_0000,
            32'h00FF_0000, 32'h0000_0000, 12'd1793, 12'd1793, 1'b0), 1'b0, 32'd0});
        // Shaped term exactly zero, then just above it.
        directed_rows.push_back('{pix(32'h8080_8080, 32'h0001_0101, 32'h0001_0101,
            32'h0001_0101, 32'h0001_0101, 12'd2175, 12'd2048, 1'b0), 1'b1, 32'h8080_8080});
        directed_rows.push_back('{pix(32'h8080_8080, 32'h0001_0101, 32'h0001_0101,
            32'h0001_0101, 32'h0001_0101, 12'd2174, 12'd2048, 1'b0), 1'b0, 32'd0});
        // One nonzero neighbor or alpha-only neighbors are not skipped.
        directed_rows.push_back('{pix(32'h00AA_5533, 32'd0, 32'd0, 32'd0, 32'h0000_0001,
            12'd2048, 12'd2048, 1'b0), 1'b0, 32'd0});
        directed_rows.push_back('{pix(32'h7F7F_7F7F, 32'hFF00_0000, 32'hFF00_0000,
            32'hFF00_0000, 32'hFF00_0000, 12'd2050, 12'd2047, 1'b0), 1'b0, 32'd0});
        directed_rows.push_back('{pix(32'hA5C3_3C5A, 32'h0080_8080, 32'h00FF_FFFF,
            32'h0000_0001, 32'h00FE_0000, 12'd4095, 12'd4095, 1'b0), 1'b0, 32'd0});
        directed_rows.push_back('{pix(32'h5A3C_C3A5, 32'd0, 32'd0, 32'd0, 32'd0,
            12'd0, 12'd0, 1'b0), 1'b1, 32'd0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].value);
        end

        // Random phases; settings change only once every pending pixel has come back.
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                case (p)
                    1: c = '{13'd0, 13'd0, 7'd0, 1'b0, bml_pkg::BLEND_ADD, 1'b1, 1'b1};
                    2: c = '{13'd4096, 13'd4096, 7'd127, 1'b1, bml_pkg::BLEND_MEAN,
                             1'b0, 1'b1};
                    3: c = '{13'd4095, 13'd0, 7'd100, 1'b0, BLEND_SPARE, 1'b1, 1'b0};
                    4: c = '{13'd1, 13'd4095, 7'd1, 1'b1, bml_pkg::BLEND_REPLACE, 1'b0, 1'b1};
                    default: begin
                        c.light_x = 13'($urandom_range(4096));
                        c.light_y = 13'($urandom_range(4096));
                        c.depth_pct = 7'($urandom_range(127));
                        c.invert = 1'($urandom_range(1));
                        c.blend = 2'($urandom_range(3));
                        c.from_frame = 1'($urandom_range(1));
                        c.show_dot = 1'($urandom_range(1));
                    end
                endcase
                program_lighting(c);
            end
            steady = (p % 2 == 1);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n == 40) begin
                    steady = 1'b0;
                end
                // Hold the sender back until the pipeline has emptied.
                if (n == 62) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    wait_drained();
                end
                send_item(rand_pixel(cur_cfg), 1'b0, 32'd0);
            end
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bml_pkg.sv
rtl/bump_map_pixel_lighting.sv
test/bump_map_pixel_lighting_tb.sv
